// ----- hw/rtl/u2c_pkg.sv -----
package u2c_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int CP_W          = 21;
  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_AW       = 2;
  localparam int FIFO_CW       = 3;

  // Result kinds carried on the master-side tuser.
  typedef enum logic [1:0] {
    KIND_CHAR   = 2'd0,
    KIND_OK     = 2'd1,
    KIND_REJECT = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
  } beat_t;

  // Up to two result beats produced by one input byte, in output order.
  typedef struct packed {
    logic [1:0] cnt;
    beat_t      first;
    beat_t      second;
  } fifo_wr_t;

  localparam logic [7:0] QUESTION_MARK = 8'h3F;

  // Unicode code point of cp1251 byte 0x80 + idx.
  function automatic logic [15:0] rev_code(input logic [5:0] idx);
    logic [15:0] c;
    case (idx)
      6'd0:  c = 16'h0402;  6'd1:  c = 16'h0403;  6'd2:  c = 16'h201A;  6'd3:  c = 16'h0453;
      6'd4:  c = 16'h201E;  6'd5:  c = 16'h2026;  6'd6:  c = 16'h2020;  6'd7:  c = 16'h2021;
      6'd8:  c = 16'h20AC;  6'd9:  c = 16'h2030;  6'd10: c = 16'h0409;  6'd11: c = 16'h2039;
      6'd12: c = 16'h040A;  6'd13: c = 16'h040C;  6'd14: c = 16'h040B;  6'd15: c = 16'h040F;
      6'd16: c = 16'h0452;  6'd17: c = 16'h2018;  6'd18: c = 16'h2019;  6'd19: c = 16'h201C;
      6'd20: c = 16'h201D;  6'd21: c = 16'h2022;  6'd22: c = 16'h2013;  6'd23: c = 16'h2014;
      6'd24: c = 16'h0098;  6'd25: c = 16'h2122;  6'd26: c = 16'h0459;  6'd27: c = 16'h203A;
      6'd28: c = 16'h045A;  6'd29: c = 16'h045C;  6'd30: c = 16'h045B;  6'd31: c = 16'h045F;
      6'd32: c = 16'h00A0;  6'd33: c = 16'h040E;  6'd34: c = 16'h045E;  6'd35: c = 16'h0408;
      6'd36: c = 16'h00A4;  6'd37: c = 16'h0490;  6'd38: c = 16'h00A6;  6'd39: c = 16'h00A7;
      6'd40: c = 16'h0401;  6'd41: c = 16'h00A9;  6'd42: c = 16'h0404;  6'd43: c = 16'h00AB;
      6'd44: c = 16'h00AC;  6'd45: c = 16'h00AD;  6'd46: c = 16'h00AE;  6'd47: c = 16'h0407;
      6'd48: c = 16'h00B0;  6'd49: c = 16'h00B1;  6'd50: c = 16'h0406;  6'd51: c = 16'h0456;
      6'd52: c = 16'h0491;  6'd53: c = 16'h00B5;  6'd54: c = 16'h00B6;  6'd55: c = 16'h00B7;
      6'd56: c = 16'h0451;  6'd57: c = 16'h2116;  6'd58: c = 16'h0454;  6'd59: c = 16'h00BB;
      6'd60: c = 16'h0458;  6'd61: c = 16'h0405;  6'd62: c = 16'h0455;  6'd63: c = 16'h0457;
      default: c = 16'h0000;
    endcase
    return c;
  endfunction

  // Maps a finished code point to its cp1251 byte. Range rules only hold for
  // two-byte sequences; everything else goes through the parallel table match.
  function automatic logic [7:0] map_code(input logic [CP_W-1:0] cp, input logic [2:0] len);
    logic [7:0]      r;
    logic            hit;
    logic [CP_W-1:0] diff;
    r   = QUESTION_MARK;
    hit = 1'b0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (!hit && ({{(CP_W-16){1'b0}}, rev_code(6'(i))} == cp)) begin
        r   = 8'h80 | {2'b00, 6'(i)};
        hit = 1'b1;
      end
    end
    if (len == 3'd2) begin
      if (cp >= CP_W'(12'h410) && cp <= CP_W'(12'h44F)) begin
        diff = cp - CP_W'(12'h350);
        r    = diff[7:0];
      end else if (cp >= CP_W'(8'h80) && cp <= CP_W'(8'hFF)) begin
        r = cp[7:0];
      end else if (cp >= CP_W'(12'h402) && cp <= CP_W'(12'h403)) begin
        diff = cp - CP_W'(12'h382);
        r    = diff[7:0];
      end
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/u2c_decode.sv -----
module u2c_decode (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic [7:0]        in_byte,
  input  logic              end_of_string,
  output u2c_pkg::fifo_wr_t wr
);
  import u2c_pkg::*;

  logic [CP_W-1:0] acc, acc_next;
  logic [1:0]      need, need_next;
  logic [2:0]      seq_len, seq_len_next;
  logic            rejected, rejected_next;
  logic            char_valid;
  logic [7:0]      char_byte;
  logic            bad;
  logic [CP_W-1:0] acc_shift;
  beat_t           char_beat, end_beat;

  assign acc_shift = {acc[CP_W-7:0], in_byte[5:0]};

  always_comb begin
    acc_next      = acc;
    need_next     = need;
    seq_len_next  = seq_len;
    rejected_next = rejected;
    char_valid    = 1'b0;
    char_byte     = in_byte;
    if (!rejected) begin
      if (need != 2'd0) begin
        if (in_byte[7:6] == 2'b10) begin
          acc_next  = acc_shift;
          need_next = need - 2'd1;
          if (need == 2'd1) begin
            char_valid   = 1'b1;
            char_byte    = map_code(acc_shift, seq_len);
            acc_next     = '0;
            seq_len_next = '0;
          end
        end else begin
          rejected_next = 1'b1;
        end
      end else if (!in_byte[7]) begin
        char_valid = 1'b1;
      end else if (in_byte[7:5] == 3'b110) begin
        acc_next     = CP_W'(in_byte[4:0]);
        need_next    = 2'd1;
        seq_len_next = 3'd2;
      end else if (in_byte[7:4] == 4'b1110) begin
        acc_next     = CP_W'(in_byte[3:0]);
        need_next    = 2'd2;
        seq_len_next = 3'd3;
      end else if (in_byte[7:3] == 5'b11110) begin
        acc_next     = CP_W'(in_byte[2:0]);
        need_next    = 2'd3;
        seq_len_next = 3'd4;
      end
    end
    bad = rejected_next || (need_next != 2'd0);
    if (end_of_string) begin
      acc_next      = '0;
      need_next     = '0;
      seq_len_next  = '0;
      rejected_next = 1'b0;
    end
  end

  always_comb begin
    char_beat.data = char_byte;
    char_beat.kind = KIND_CHAR;
    end_beat.data  = 8'h00;
    end_beat.kind  = bad ? KIND_REJECT : KIND_OK;
    wr.cnt         = fire ? (2'(char_valid) + 2'(end_of_string)) : 2'd0;
    wr.first       = char_valid ? char_beat : end_beat;
    wr.second      = end_beat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc      <= '0;
      need     <= '0;
      seq_len  <= '0;
      rejected <= 1'b0;
    end else if (fire) begin
      acc      <= acc_next;
      need     <= need_next;
      seq_len  <= seq_len_next;
      rejected <= rejected_next;
    end
  end

  // A rejected string yields no characters until its end mark.
  a_no_char_after_reject: assert property (@(posedge clk) disable iff (rst)
    (fire && rejected) |-> (wr.cnt == 2'(end_of_string)))
    else $error("character emitted after rejection");

  // A sequence in progress always still has fewer bytes to come than its length.
  a_len_matches_need: assert property (@(posedge clk) disable iff (rst)
    (need != 2'd0) |-> (3'(need) < seq_len))
    else $error("sequence length out of step with pending bytes");

endmodule

// ----- hw/rtl/u2c_fifo.sv -----
module u2c_fifo (
  input  logic              clk,
  input  logic              rst,
  input  u2c_pkg::fifo_wr_t wr,
  input  logic              pop,
  output u2c_pkg::beat_t    head,
  output logic              not_empty,
  output logic              room2
);
  import u2c_pkg::*;

  beat_t              mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr, rd_ptr;
  logic [FIFO_CW-1:0] count;
  logic               do_pop;

  assign not_empty = (count != '0);
  assign room2     = (count <= FIFO_CW'(FIFO_DEPTH - 2));
  assign head      = mem[rd_ptr];
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (wr.cnt != 2'd0) begin
      mem[wr_ptr] <= wr.first;
    end
    if (wr.cnt == 2'd2) begin
      mem[FIFO_AW'(wr_ptr + FIFO_AW'(1))] <= wr.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= FIFO_AW'(wr_ptr + FIFO_AW'(wr.cnt));
      if (do_pop) begin
        rd_ptr <= FIFO_AW'(rd_ptr + FIFO_AW'(1));
      end
      count <= FIFO_CW'(count + FIFO_CW'(wr.cnt) - FIFO_CW'(do_pop));
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FIFO_CW'(FIFO_DEPTH))
    else $error("result queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (wr.cnt != 2'd0) |-> room2)
    else $error("result queue written without room");

  a_write_count: assert property (@(posedge clk) disable iff (rst)
    wr.cnt != 2'd3)
    else $error("more than two results from one byte");

endmodule

// ----- hw/rtl/utf8_to_cp1251_decoder.sv -----
// Channel | Dir | tdata                 | tuser                  | tlast
// s_*     | in  | [7:0] in_byte         | -                      | end_of_string
// m_*     | out | [7:0] out_byte        | [1:0] kind             | -
//
// One input beat is taken every cycle while the result queue has room for two beats.
// A taken byte waits in the input register and is decoded out of it once the queue has
// room for two beats; its results are written into the queue, whose head drives m_*
// directly, and further beats follow at one per cycle while m_tready is high.
// A byte that both finishes a character and ends the string gives two result beats.
// rst is synchronous and clears the decoder state, the input register and the queue.
// When m_tready is low the four-entry queue fills and s_tready drops once it holds more
// than two beats and a byte is held; no beat is lost or repeated under any stall pattern.
module utf8_to_cp1251_decoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       s_tlast,   // end_of_string
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic [1:0] m_tuser    // [1:0] kind
);
  import u2c_pkg::*;

  // Input register: holds one accepted byte until the decoder takes it.
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_eos;
  logic       fire;
  logic       room2;
  fifo_wr_t   wr;
  beat_t      head;

  // The decoder consumes the held byte only when the queue can take both of
  // its possible results.
  assign fire     = in_valid && room2;
  assign s_tready = !in_valid || room2;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_eos  <= s_tlast;
    end
  end

  // Sequence gathering, range rules and the reverse table lookup.
  u2c_decode u_decode (
    .clk           (clk),
    .rst           (rst),
    .fire          (fire),
    .in_byte       (in_byte),
    .end_of_string (in_eos),
    .wr            (wr)
  );

  // Result queue; its head drives the master side directly.
  u2c_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .wr        (wr),
    .pop       (m_tready),
    .head      (head),
    .not_empty (m_tvalid),
    .room2     (room2)
  );

  assign m_tdata = head.data;
  assign m_tuser = head.kind;

endmodule
